FILE: src/rffsa_pkg.sv
// ----------------------------------------------------------------------------
// rffsa_pkg : shared types, constants and helpers of the seat allocator
// Sizes of the row store, field widths, codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package rffsa_pkg;

  // Sizing of the row store
  localparam int MAX_ROWS  = 256;
  localparam int SEAT_BITS = 16;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Fixed field widths
  localparam int MODE_W      = 1;
  localparam int NEED_W      = 24;
  localparam int MAXROW_W    = 8;
  localparam int ROW_FIELD_W = 8;
  localparam int START_W     = 16;
  localparam int ROWS_CFG_W  = 9;
  localparam int SEATS_CFG_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  // Width of the shared subtractor operands
  localparam int ARG_W = (NEED_W > SEAT_BITS) ? NEED_W : SEAT_BITS;

  // Width used to clamp the row limit
  localparam int LIM_W = (ROW_W + 1 > ROWS_CFG_W) ? ROW_W + 1 : ROWS_CFG_W;

  // Width used to saturate the per-row seat count
  localparam int CAP_CMP_W = 33;
  localparam logic [CAP_CMP_W-1:0] SEAT_MAX = (CAP_CMP_W'(1) << SEAT_BITS) - CAP_CMP_W'(1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEATS_PER_ROW = 1'b1;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_GATHER  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_SCATTER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLR,
    ST_FIN,
    ST_RESP
  } state_t;

  // Row store access issued by the sequencer
  typedef struct packed {
    logic                 we;
    logic [ROW_W-1:0]     waddr;
    logic [SEAT_BITS-1:0] wdata;
    logic                 re;
    logic [ROW_W-1:0]     raddr;
  } mem_req_t;

  // Saturate the configured seat count to what a row counter holds
  function automatic logic [SEAT_BITS-1:0] seat_cap(input logic [SEATS_CFG_W-1:0] spr);
    logic [CAP_CMP_W-1:0] v;
    v = CAP_CMP_W'(spr);
    if (v > SEAT_MAX) begin
      v = SEAT_MAX;
    end
    return SEAT_BITS'(v);
  endfunction

  // Clamp the requested row limit to the rows in use
  function automatic logic [ROW_W-1:0] row_top(input logic [ROWS_CFG_W-1:0] rows,
                                               input logic [MAXROW_W-1:0]   mr);
    logic [LIM_W-1:0] used;
    logic [LIM_W-1:0] lim;
    used = LIM_W'(rows);
    if (rows == '0) begin
      used = LIM_W'(1);
    end else if (used > LIM_W'(MAX_ROWS)) begin
      used = LIM_W'(MAX_ROWS);
    end
    lim = used - LIM_W'(1);
    if (LIM_W'(mr) > lim) begin
      return ROW_W'(lim);
    end
    return ROW_W'(mr);
  endfunction

endpackage

`default_nettype wire

FILE: src/rffsa_in_if.sv
// ----------------------------------------------------------------------------
// rffsa_in_if : request channel of the seat allocator
// Valid/ready handshake carrying one seat request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rffsa_in_if
  import rffsa_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [NEED_W-1:0]   group_size;
  logic [MAXROW_W-1:0] max_row;

  modport source (output valid, output mode, output group_size, output max_row, input ready);
  modport sink   (input valid, input mode, input group_size, input max_row, output ready);
endinterface

`default_nettype wire

FILE: src/rffsa_out_if.sv
// ----------------------------------------------------------------------------
// rffsa_out_if : result channel of the seat allocator
// Valid/ready handshake carrying one grant or refusal.
// ----------------------------------------------------------------------------
`default_nettype none

interface rffsa_out_if
  import rffsa_pkg::*;
  ;
  logic                   valid;
  logic                   ready;
  logic                   granted;
  logic [ROW_FIELD_W-1:0] row;
  logic [START_W-1:0]     first_seat;

  modport source (output valid, output granted, output row, output first_seat, input ready);
  modport sink   (input valid, input granted, input row, input first_seat, output ready);
endinterface

`default_nettype wire

FILE: src/rffsa_ram.sv
// ----------------------------------------------------------------------------
// rffsa_ram : generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rffsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/rffsa_alu.sv
// ----------------------------------------------------------------------------
// rffsa_alu : shared subtract/compare unit
// Computes a - b with borrow and zero flags for the seat comparisons and updates.
// ----------------------------------------------------------------------------
`default_nettype none

module rffsa_alu
  import rffsa_pkg::*;
(
  input  wire logic [ARG_W-1:0] a,
  input  wire logic [ARG_W-1:0] b,
  output logic      [ARG_W-1:0] diff,
  output logic                  borrow,
  output logic                  zero
);

  logic [ARG_W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[ARG_W-1:0];
  assign borrow = full[ARG_W];
  assign zero   = (full[ARG_W-1:0] == '0);

endmodule

`default_nettype wire

FILE: src/rffsa_ctrl.sv
// ----------------------------------------------------------------------------
// rffsa_ctrl : request sequencer of the seat allocator
// Streams rows through the shared subtractor, clears rows, writes the hit row
// back and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rffsa_ctrl
  import rffsa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request side
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [MODE_W-1:0]      in_mode,
  input  wire logic [NEED_W-1:0]      in_group_size,
  input  wire logic [MAXROW_W-1:0]    in_max_row,
  // result side
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_granted,
  output logic [ROW_FIELD_W-1:0]      out_row,
  output logic [START_W-1:0]          out_first_seat,
  // configuration
  input  wire logic [ROWS_CFG_W-1:0]  rows_in_use,
  input  wire logic [SEAT_BITS-1:0]   cap,
  // row store
  output mem_req_t                    mem_req,
  input  wire logic [SEAT_BITS-1:0]   row_free
);

  state_t state_r, state_nxt;

  logic                 chk_vld_r, chk_vld_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_load;

  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [NEED_W-1:0]    need_r, need_nxt;
  logic [NEED_W-1:0]    left_r, left_nxt;
  logic [ROW_W-1:0]     top_r, top_nxt;
  logic [ROW_W-1:0]     ptr_r, ptr_nxt;
  logic [ROW_W-1:0]     chk_row_r, chk_row_nxt;
  logic [ROW_W-1:0]     hit_row_r, hit_row_nxt;
  logic [SEAT_BITS-1:0] hit_free_r, hit_free_nxt;
  logic [SEAT_BITS-1:0] upd_r, upd_nxt;
  logic                 grant_r, grant_nxt;
  logic [ROW_W-1:0]     res_row_r, res_row_nxt;
  logic [SEAT_BITS-1:0] res_start_r, res_start_nxt;

  logic                   out_granted_r;
  logic [ROW_FIELD_W-1:0] out_row_r;
  logic [START_W-1:0]     out_start_r;

  logic [ARG_W-1:0] alu_a, alu_b, alu_diff;
  logic             alu_borrow, alu_zero;
  logic             hit;

  rffsa_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    need_r      <= need_nxt;
    left_r      <= left_nxt;
    top_r       <= top_nxt;
    ptr_r       <= ptr_nxt;
    chk_row_r   <= chk_row_nxt;
    hit_row_r   <= hit_row_nxt;
    hit_free_r  <= hit_free_nxt;
    upd_r       <= upd_nxt;
    grant_r     <= grant_nxt;
    res_row_r   <= res_row_nxt;
    res_start_r <= res_start_nxt;
    if (out_load) begin
      out_granted_r <= grant_r;
      out_row_r     <= ROW_FIELD_W'(res_row_r);
      out_start_r   <= START_W'(res_start_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    chk_vld_nxt   = chk_vld_r;
    mode_nxt      = mode_r;
    need_nxt      = need_r;
    left_nxt      = left_r;
    top_nxt       = top_r;
    ptr_nxt       = ptr_r;
    chk_row_nxt   = chk_row_r;
    hit_row_nxt   = hit_row_r;
    hit_free_nxt  = hit_free_r;
    upd_nxt       = upd_r;
    grant_nxt     = grant_r;
    res_row_nxt   = res_row_r;
    res_start_nxt = res_start_r;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    mem_req       = '0;
    alu_a         = '0;
    alu_b         = '0;
    hit           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt    = in_mode;
          need_nxt    = in_group_size;
          left_nxt    = in_group_size;
          top_nxt     = row_top(rows_in_use, in_max_row);
          ptr_nxt     = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one row read per cycle, check the row read last cycle
        mem_req.re    = 1'b1;
        mem_req.raddr = ptr_r;
        ptr_nxt       = ptr_r + 1'b1;
        chk_row_nxt   = ptr_r;
        chk_vld_nxt   = 1'b1;
        if (chk_vld_r) begin
          if (mode_r == MODE_GATHER) begin
            alu_a = ARG_W'(row_free);
            alu_b = ARG_W'(need_r);
            hit   = !alu_borrow;
          end else begin
            alu_a = ARG_W'(left_r);
            alu_b = ARG_W'(row_free);
            hit   = (row_free != '0) && (alu_borrow || alu_zero);
          end
          if (hit) begin
            hit_row_nxt  = chk_row_r;
            hit_free_nxt = row_free;
            upd_nxt      = alu_diff[SEAT_BITS-1:0];
            ptr_nxt      = '0;
            chk_vld_nxt  = 1'b0;
            if ((mode_r == MODE_SCATTER) && (chk_row_r != '0)) begin
              state_nxt = ST_CLR;
            end else begin
              state_nxt = ST_FIN;
            end
          end else begin
            if (mode_r == MODE_SCATTER) begin
              left_nxt = alu_diff[NEED_W-1:0];
            end
            if (chk_row_r == top_r) begin
              grant_nxt     = 1'b0;
              res_row_nxt   = '0;
              res_start_nxt = '0;
              state_nxt     = ST_RESP;
            end
          end
        end
      end

      ST_CLR: begin
        // empty every row ahead of the last one
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = '0;
        ptr_nxt       = ptr_r + 1'b1;
        if (ROW_W'(ptr_r + 1'b1) == hit_row_r) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hit_row_r;
        grant_nxt     = 1'b1;
        if (mode_r == MODE_GATHER) begin
          alu_a         = ARG_W'(cap);
          alu_b         = ARG_W'(hit_free_r);
          mem_req.wdata = upd_r;
          res_row_nxt   = hit_row_r;
          res_start_nxt = alu_diff[SEAT_BITS-1:0];
        end else begin
          alu_a         = ARG_W'(hit_free_r);
          alu_b         = ARG_W'(left_r);
          mem_req.wdata = alu_diff[SEAT_BITS-1:0];
          res_row_nxt   = '0;
          res_start_nxt = '0;
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (!out_vld_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_vld_nxt = out_vld_r && !out_ready;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_granted    = out_granted_r;
  assign out_row        = out_row_r;
  assign out_first_seat = out_start_r;

`ifndef SYNTHESIS
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_granted_r |-> (out_row_r == '0) && (out_start_r == '0))
    else $error("refused result carries a row or seat");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) && !out_vld_r |=> out_vld_r)
    else $error("finished result not moved to output register");
`endif

endmodule

`default_nettype wire

FILE: src/row_first_fit_seat_allocator.sv
// ----------------------------------------------------------------------------
// row_first_fit_seat_allocator : row-first-fit seat allocator
// Keeps a free-seat count per row; grants gather and scatter requests.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_ch    sink       valid/ready          mode, group_size, max_row
//   out_ch   source     valid/ready          granted, row, first_seat
//   cfg_*    sink       cfg_we (no ready)    cfg_idx, cfg_data
//
// A request scans rows from row 0 up to the hit row, or up to the row limit
// for a refusal; a scatter then empties every row ahead of the last row,
// the hit row is written back, and the result loads into the output
// register. The block takes no new request while one is in work; the next
// request is taken in the cycle after the result loads.
// The row store has one read and one write port and all seat subtractions go
// through one shared subtractor, one row per cycle. Reset and any
// configuration write reload all rows at once through per-row valid bits;
// there is no clearing pass. A result waits in the output register while
// the next request is accepted; a second result holds the sequencer until
// the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module row_first_fit_seat_allocator
  import rffsa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  rffsa_in_if.sink                    in_ch,
  rffsa_out_if.source                 out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [ROWS_CFG_W-1:0]  rows_r;
  logic [SEATS_CFG_W-1:0] spr_r;
  logic [SEAT_BITS-1:0]   cap;

  // per-row valid: a clear bit means the row still holds the full capacity
  logic [MAX_ROWS-1:0]    valid_r;
  logic                   vld_q_r;

  mem_req_t               mem_req;
  logic [SEAT_BITS-1:0]   ram_q;
  logic [SEAT_BITS-1:0]   row_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_CFG_W'(MAX_ROWS);
      spr_r  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROWS_IN_USE:   rows_r <= cfg_data[ROWS_CFG_W-1:0];
        REG_SEATS_PER_ROW: spr_r  <= cfg_data[SEATS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cap = seat_cap(spr_r);

  // drop all row contents on reset or reconfiguration; mark rows as written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cfg_we) begin
      valid_r <= '0;
    end else if (mem_req.we) begin
      valid_r[mem_req.waddr] <= 1'b1;
    end
  end

  // sample the valid bit alongside the registered RAM read
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      vld_q_r <= valid_r[mem_req.raddr];
    end
  end

  assign row_free = vld_q_r ? ram_q : cap;

  rffsa_ram #(
    .WIDTH (SEAT_BITS),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (ram_q)
  );

  rffsa_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_mode        (in_ch.mode),
    .in_group_size  (in_ch.group_size),
    .in_max_row     (in_ch.max_row),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_granted    (out_ch.granted),
    .out_row        (out_ch.row),
    .out_first_seat (out_ch.first_seat),
    .rows_in_use    (rows_r),
    .cap            (cap),
    .mem_req        (mem_req),
    .row_free       (row_free)
  );

`ifndef SYNTHESIS
  a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (valid_r == '0))
    else $error("row contents survive a configuration write");
`endif

endmodule

`default_nettype wire
